// ----- src/xml_markup_detector_assert.svh -----
// ----------------------------------------------------------------------------
// xml_markup_detector assertion macros
// Clocked assertion helpers shared by the detector modules.
// ----------------------------------------------------------------------------
`ifndef XML_MARKUP_DETECTOR_ASSERT_SVH
`define XML_MARKUP_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS
`define XMD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define XMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define XMD_ASSERT(lbl, prop, msg)
`define XMD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- src/xmd_pkg.sv -----
// ----------------------------------------------------------------------------
// xmd_pkg
// Types, character codes and pattern tables of the XML markup detector.
// ----------------------------------------------------------------------------
package xmd_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	localparam logic [2:0] DECL_LEN  = 3'd5;
	localparam logic [3:0] CDATA_LEN = 4'd9;
	localparam logic [2:0] NS_LEN    = 3'd5;

	localparam logic [6:0] CONF_DECL   = 7'd95;
	localparam logic [6:0] CONF_CDATA  = 7'd90;
	localparam logic [6:0] CONF_BASE   = 7'd72;
	localparam logic [6:0] CONF_OPEN1  = 7'd5;
	localparam logic [6:0] CONF_OPEN2  = 7'd10;
	localparam logic [6:0] CONF_CLOSE  = 7'd8;
	localparam logic [6:0] CONF_SELF   = 7'd5;
	localparam logic [6:0] CONF_ASSIGN = 7'd5;
	localparam logic [6:0] CONF_NS     = 7'd10;
	localparam logic [6:0] CONF_MAX    = 7'd95;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
	} text_in_t;

	typedef struct packed {
		logic       looks_xml;
		logic [6:0] confidence_pct;
	} verdict_t;

	typedef struct packed {
		logic lt;
		logic gt;
		logic slash;
		logic colon;
		logic eq;
		logic start;
		logic namech;
		logic space;
		logic name_end;
	} char_class_t;

	typedef struct packed {
		text_in_t    req;
		char_class_t cls;
	} entry_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LT,
		PH_SLASH,
		PH_PREFIX,
		PH_COLON,
		PH_LOCAL,
		PH_TAIL
	} phase_t;

	typedef struct packed {
		logic drop;
		logic complete;
		logic tail;
		logic from_local;
		logic load_closing;
		logic closing_val;
	} scan_ctl_t;

	function automatic logic [7:0] decl_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0: ch = 8'h3C;
			3'd1: ch = 8'h3F;
			3'd2: ch = 8'h78;
			3'd3: ch = 8'h6D;
			3'd4: ch = 8'h6C;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] cdata_char(input logic [3:0] idx);
		logic [7:0] ch;
		unique case (idx)
			4'd0: ch = 8'h3C;
			4'd1: ch = 8'h21;
			4'd2: ch = 8'h5B;
			4'd3: ch = 8'h43;
			4'd4: ch = 8'h44;
			4'd5: ch = 8'h41;
			4'd6: ch = 8'h54;
			4'd7: ch = 8'h41;
			4'd8: ch = 8'h5B;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] ns_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0: ch = 8'h78;
			3'd1: ch = 8'h6D;
			3'd2: ch = 8'h6C;
			3'd3: ch = 8'h6E;
			3'd4: ch = 8'h73;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// ----- src/xmd_front.sv -----
// ----------------------------------------------------------------------------
// xmd_front
// Accepts text bytes and tags each with its character class.
// ----------------------------------------------------------------------------
module xmd_front (
	input  logic              byte_valid,
	output logic              byte_stall,
	input  xmd_pkg::text_in_t byte_data,
	input  logic              q_full,
	output logic              q_push,
	output xmd_pkg::entry_t   q_entry
);

	logic [7:0] c;
	logic       alpha;
	logic       digit;

	assign c     = byte_data.text_byte;
	assign alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	assign digit = (c >= 8'h30 && c <= 8'h39);

	always_comb begin
		q_entry.req          = byte_data;
		q_entry.cls.lt       = (c == xmd_pkg::CH_LT);
		q_entry.cls.gt       = (c == xmd_pkg::CH_GT);
		q_entry.cls.slash    = (c == xmd_pkg::CH_SLASH);
		q_entry.cls.colon    = (c == xmd_pkg::CH_COLON);
		q_entry.cls.eq       = (c == xmd_pkg::CH_EQ);
		q_entry.cls.start    = alpha || (c == xmd_pkg::CH_USCORE);
		q_entry.cls.namech   = alpha || digit || (c == xmd_pkg::CH_USCORE)
			|| (c == xmd_pkg::CH_DASH) || (c == xmd_pkg::CH_DOT);
		q_entry.cls.space    = (c == xmd_pkg::CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
		q_entry.cls.name_end = (c == xmd_pkg::CH_SLASH) || (c == xmd_pkg::CH_SPACE)
			|| (c == xmd_pkg::CH_TAB) || (c == xmd_pkg::CH_LF) || (c == xmd_pkg::CH_CR);
	end

	assign byte_stall = q_full;
	assign q_push     = byte_valid && !q_full;

endmodule

// ----- src/xmd_queue.sv -----
// ----------------------------------------------------------------------------
// xmd_queue
// Short request queue between the classifier and the scanner.
// ----------------------------------------------------------------------------
`include "xml_markup_detector_assert.svh"

module xmd_queue #(
	parameter int DEPTH = xmd_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  xmd_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output xmd_pkg::entry_t head_entry
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	xmd_pkg::entry_t slots_q [DEPTH];
	logic [IW-1:0]   wr_ptr_q;
	logic [IW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_entry = slots_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`XMD_ASSERT(a_count_bound, count_q <= FULL_CNT, "queue count exceeds depth")
	`XMD_ASSERT_NEXT(a_ptr_gap, 1'b1, (count_q == FULL_CNT) || (count_q == '0) || (wr_ptr_q != rd_ptr_q), "queue pointers disagree with count")

endmodule

// ----- src/xmd_back.sv -----
// ----------------------------------------------------------------------------
// xmd_back
// Tag scanner, marker matchers and verdict register.
// ----------------------------------------------------------------------------
`include "xml_markup_detector_assert.svh"

module xmd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  xmd_pkg::entry_t   head_entry,
	output logic              pop,
	output logic              verdict_valid,
	input  logic              verdict_stall,
	output xmd_pkg::verdict_t verdict_data
);

	xmd_pkg::phase_t    phase_q, phase_d;
	xmd_pkg::scan_ctl_t ctl;
	xmd_pkg::char_class_t cls;
	logic [7:0] c;
	logic       last;

	logic       closing_q, closing_n;
	logic [2:0] decl_q, decl_n, decl_inc;
	logic [3:0] cdata_q, cdata_n, cdata_inc;
	logic       saw_decl_q, saw_decl_n;
	logic       saw_cdata_q, saw_cdata_n;
	logic [1:0] open_cnt_q, open_cnt_n;
	logic       saw_close_q, saw_close_n;
	logic       saw_self_q, saw_self_n;
	logic       saw_assign_q, saw_assign_n;
	logic       saw_ns_q, saw_ns_n;
	logic [2:0] p_ns_q, p_ns_n, p_ns_base, p_ns_inc;
	logic       p_found_q, p_found_n, p_found_base;
	logic       p_assign_q, p_assign_n, p_assign_base;
	logic       p_tail_q, p_tail_n;
	logic       p_slash_q, p_slash_n, p_slash_base;
	logic [6:0] conf_sum;
	xmd_pkg::verdict_t verdict_n;
	logic       verdict_valid_q;
	xmd_pkg::verdict_t verdict_q;

	assign c    = head_entry.req.text_byte;
	assign last = head_entry.req.last_byte;
	assign cls  = head_entry.cls;
	assign pop  = head_valid && (!last || !verdict_valid_q || !verdict_stall);

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			xmd_pkg::PH_LT: begin
				if (cls.slash) phase_d = xmd_pkg::PH_SLASH;
				else if (cls.start) phase_d = xmd_pkg::PH_PREFIX;
				else phase_d = cls.lt ? xmd_pkg::PH_LT : xmd_pkg::PH_IDLE;
			end
			xmd_pkg::PH_SLASH: begin
				if (cls.start) phase_d = xmd_pkg::PH_PREFIX;
				else phase_d = cls.lt ? xmd_pkg::PH_LT : xmd_pkg::PH_IDLE;
			end
			xmd_pkg::PH_PREFIX: begin
				if (cls.colon) phase_d = xmd_pkg::PH_COLON;
				else if (!cls.namech) phase_d = cls.lt ? xmd_pkg::PH_LT : xmd_pkg::PH_IDLE;
			end
			xmd_pkg::PH_COLON: begin
				if (cls.start) phase_d = xmd_pkg::PH_LOCAL;
				else phase_d = cls.lt ? xmd_pkg::PH_LT : xmd_pkg::PH_IDLE;
			end
			xmd_pkg::PH_LOCAL: begin
				if (cls.namech) phase_d = xmd_pkg::PH_LOCAL;
				else if (cls.gt) phase_d = xmd_pkg::PH_IDLE;
				else if (cls.name_end) phase_d = xmd_pkg::PH_TAIL;
				else phase_d = cls.lt ? xmd_pkg::PH_LT : xmd_pkg::PH_IDLE;
			end
			xmd_pkg::PH_TAIL: begin
				phase_d = cls.gt ? xmd_pkg::PH_IDLE : xmd_pkg::PH_TAIL;
			end
			default: begin
				phase_d = cls.lt ? xmd_pkg::PH_LT : xmd_pkg::PH_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (phase_q)
			xmd_pkg::PH_LT: begin
				if (cls.slash || cls.start) begin
					ctl.load_closing = 1'b1;
					ctl.closing_val  = cls.slash;
				end else begin
					ctl.drop = 1'b1;
				end
			end
			xmd_pkg::PH_SLASH: ctl.drop = !cls.start;
			xmd_pkg::PH_PREFIX: ctl.drop = !cls.colon && !cls.namech;
			xmd_pkg::PH_COLON: ctl.drop = !cls.start;
			xmd_pkg::PH_LOCAL: begin
				if (!cls.namech) begin
					if (cls.gt) begin
						ctl.complete = 1'b1;
					end else if (cls.name_end) begin
						ctl.tail       = 1'b1;
						ctl.from_local = 1'b1;
					end else begin
						ctl.drop = 1'b1;
					end
				end
			end
			xmd_pkg::PH_TAIL: begin
				ctl.complete = cls.gt;
				ctl.tail     = !cls.gt;
			end
			default: ctl.drop = 1'b1;
		endcase
	end

	always_comb begin
		decl_inc  = decl_q + 1'b1;
		cdata_inc = cdata_q + 1'b1;
		decl_n      = (c == xmd_pkg::decl_char(decl_q)) ? decl_inc : {2'b00, cls.lt};
		cdata_n     = (c == xmd_pkg::cdata_char(cdata_q)) ? cdata_inc : {3'b000, cls.lt};
		saw_decl_n  = saw_decl_q;
		saw_cdata_n = saw_cdata_q;
		if (decl_n == xmd_pkg::DECL_LEN) begin
			saw_decl_n = 1'b1;
			decl_n     = '0;
		end
		if (cdata_n == xmd_pkg::CDATA_LEN) begin
			saw_cdata_n = 1'b1;
			cdata_n     = '0;
		end

		p_ns_base     = ctl.from_local ? 3'd0 : p_ns_q;
		p_found_base  = ctl.from_local ? 1'b0 : p_found_q;
		p_assign_base = ctl.from_local ? 1'b0 : p_assign_q;
		p_slash_base  = ctl.from_local ? 1'b0 : p_slash_q;
		p_ns_inc      = p_ns_base + 1'b1;

		p_ns_n     = p_ns_q;
		p_found_n  = p_found_q;
		p_assign_n = p_assign_q;
		p_tail_n   = p_tail_q;
		p_slash_n  = p_slash_q;
		if (ctl.drop || ctl.complete) begin
			p_ns_n     = '0;
			p_found_n  = 1'b0;
			p_assign_n = 1'b0;
			p_tail_n   = 1'b0;
			p_slash_n  = 1'b0;
		end else if (ctl.tail) begin
			p_tail_n   = 1'b1;
			p_assign_n = p_assign_base || cls.eq;
			p_ns_n     = (c == xmd_pkg::ns_char(p_ns_base)) ? p_ns_inc
				: {2'b00, c == xmd_pkg::ns_char(3'd0)};
			p_found_n  = p_found_base;
			if (p_ns_n == xmd_pkg::NS_LEN) begin
				p_found_n = 1'b1;
				p_ns_n    = '0;
			end
			p_slash_n = cls.space ? p_slash_base : cls.slash;
		end

		closing_n = closing_q;
		if (ctl.load_closing) closing_n = ctl.closing_val;
		else if (ctl.drop || ctl.complete) closing_n = 1'b0;

		open_cnt_n   = open_cnt_q;
		saw_close_n  = saw_close_q;
		saw_self_n   = saw_self_q;
		saw_assign_n = saw_assign_q;
		saw_ns_n     = saw_ns_q;
		if (ctl.complete) begin
			if (closing_q) begin
				saw_close_n = 1'b1;
			end else begin
				if (open_cnt_q != 2'd2) open_cnt_n = open_cnt_q + 1'b1;
				saw_ns_n     = saw_ns_q || p_found_q;
				saw_assign_n = saw_assign_q || p_assign_q;
				saw_self_n   = saw_self_q || (p_tail_q && p_slash_q);
			end
		end
	end

	always_comb begin
		conf_sum = xmd_pkg::CONF_BASE
			+ ((open_cnt_n == 2'd2) ? xmd_pkg::CONF_OPEN2 : xmd_pkg::CONF_OPEN1)
			+ (saw_close_n ? xmd_pkg::CONF_CLOSE : 7'd0)
			+ (saw_self_n ? xmd_pkg::CONF_SELF : 7'd0)
			+ (saw_assign_n ? xmd_pkg::CONF_ASSIGN : 7'd0)
			+ (saw_ns_n ? xmd_pkg::CONF_NS : 7'd0);
		verdict_n = '0;
		if (saw_decl_n) begin
			verdict_n.looks_xml      = 1'b1;
			verdict_n.confidence_pct = xmd_pkg::CONF_DECL;
		end else if (saw_cdata_n) begin
			verdict_n.looks_xml      = 1'b1;
			verdict_n.confidence_pct = xmd_pkg::CONF_CDATA;
		end else if (open_cnt_n != 2'd0 && (saw_close_n || saw_self_n || saw_ns_n)) begin
			verdict_n.looks_xml      = 1'b1;
			verdict_n.confidence_pct =
				(conf_sum > xmd_pkg::CONF_MAX) ? xmd_pkg::CONF_MAX : conf_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= xmd_pkg::PH_IDLE;
			closing_q    <= 1'b0;
			decl_q       <= '0;
			cdata_q      <= '0;
			saw_decl_q   <= 1'b0;
			saw_cdata_q  <= 1'b0;
			open_cnt_q   <= '0;
			saw_close_q  <= 1'b0;
			saw_self_q   <= 1'b0;
			saw_assign_q <= 1'b0;
			saw_ns_q     <= 1'b0;
			p_ns_q       <= '0;
			p_found_q    <= 1'b0;
			p_assign_q   <= 1'b0;
			p_tail_q     <= 1'b0;
			p_slash_q    <= 1'b0;
		end else if (pop) begin
			if (last) begin
				phase_q      <= xmd_pkg::PH_IDLE;
				closing_q    <= 1'b0;
				decl_q       <= '0;
				cdata_q      <= '0;
				saw_decl_q   <= 1'b0;
				saw_cdata_q  <= 1'b0;
				open_cnt_q   <= '0;
				saw_close_q  <= 1'b0;
				saw_self_q   <= 1'b0;
				saw_assign_q <= 1'b0;
				saw_ns_q     <= 1'b0;
				p_ns_q       <= '0;
				p_found_q    <= 1'b0;
				p_assign_q   <= 1'b0;
				p_tail_q     <= 1'b0;
				p_slash_q    <= 1'b0;
			end else begin
				phase_q      <= phase_d;
				closing_q    <= closing_n;
				decl_q       <= decl_n;
				cdata_q      <= cdata_n;
				saw_decl_q   <= saw_decl_n;
				saw_cdata_q  <= saw_cdata_n;
				open_cnt_q   <= open_cnt_n;
				saw_close_q  <= saw_close_n;
				saw_self_q   <= saw_self_n;
				saw_assign_q <= saw_assign_n;
				saw_ns_q     <= saw_ns_n;
				p_ns_q       <= p_ns_n;
				p_found_q    <= p_found_n;
				p_assign_q   <= p_assign_n;
				p_tail_q     <= p_tail_n;
				p_slash_q    <= p_slash_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid_q <= 1'b0;
		end else if (pop && last) begin
			verdict_valid_q <= 1'b1;
		end else if (!verdict_stall) begin
			verdict_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && last) begin
			verdict_q <= verdict_n;
		end
	end

	assign verdict_valid = verdict_valid_q;
	assign verdict_data  = verdict_q;

	`XMD_ASSERT(a_open_sat, open_cnt_q != 2'd3, "open tag count past saturation")
	`XMD_ASSERT(a_conf_range, !verdict_valid_q || (verdict_q.confidence_pct <= xmd_pkg::CONF_MAX && (verdict_q.looks_xml || verdict_q.confidence_pct == 7'd0)), "verdict confidence out of range")
	`XMD_ASSERT_NEXT(a_last_resets, pop && last, phase_q == xmd_pkg::PH_IDLE && open_cnt_q == 2'd0 && !saw_decl_q && verdict_valid_q, "state not cleared after last byte")

endmodule

// ----- src/xml_markup_detector.sv -----
// ----------------------------------------------------------------------------
// xml_markup_detector
// Streaming check of whether a byte string looks like XML.
// ----------------------------------------------------------------------------
// One text byte is taken per request, one per cycle while the queue has room.
// A classifier tags each byte and writes it into a short queue; the scanner
// pops one byte per cycle, follows "<?xml", "<![CDATA[" and colon-qualified
// tags, and on the byte marked last loads a verdict with a confidence in
// hundredths into an output register. The last byte always passes through a
// queue slot before the scanner pops it and sets verdict_valid; the scanner
// only waits when a finished verdict is still held by a stalled consumer and
// the next last byte arrives, and the input stalls once the queue is full.
// ----------------------------------------------------------------------------
module xml_markup_detector #(
	parameter int QUEUE_DEPTH = xmd_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  xmd_pkg::text_in_t byte_data,
	output logic              verdict_valid,
	input  logic              verdict_stall,
	output xmd_pkg::verdict_t verdict_data
);

	logic            q_full;
	logic            q_push;
	xmd_pkg::entry_t q_entry;
	logic            q_pop;
	logic            head_valid;
	xmd_pkg::entry_t head_entry;

	xmd_front u_front (
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (q_entry)
	);

	xmd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	xmd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_entry    (head_entry),
		.pop           (q_pop),
		.verdict_valid (verdict_valid),
		.verdict_stall (verdict_stall),
		.verdict_data  (verdict_data)
	);

endmodule
